// File: src/assert_macros.svh
// Assertion helpers used by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// File: src/ntt_pkg.sv
package ntt_pkg;

	localparam int LENGTH     = 1024;
	localparam int COEFF_BITS = 31;
	localparam int Q_W        = 31;
	localparam int IDX_W      = $clog2(LENGTH);
	localparam int LOG2N      = IDX_W;
	localparam int STG_W      = $clog2(LOG2N + 1);
	localparam int MCNT_W     = $clog2(Q_W);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_FIN  = 1'b1;

	localparam logic [2:0] REG_MODULUS  = 3'd0;
	localparam logic [2:0] REG_FWD_ROOT = 3'd1;
	localparam logic [2:0] REG_INV_ROOT = 3'd2;
	localparam logic [2:0] REG_INV_LEN  = 3'd3;
	localparam logic [2:0] REG_INV_MODE = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ILF, ST_STG, ST_SQR,
		ST_RD_LO, ST_RD_HI, ST_CAP_V, ST_MUL_U, ST_MUL_V, ST_MUL_D,
		ST_WR_LO, ST_WR_HI, ST_MUL_W,
		ST_SC_RD, ST_SC_WAIT, ST_SC_MUL, ST_SC_WR, ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic [Q_W-1:0] q;
		logic [Q_W-1:0] fwd_root;
		logic [Q_W-1:0] bwd_root;
		logic [Q_W-1:0] ilf;
		logic           inv_mode;
	} cfg_t;

	typedef struct packed {
		logic                  re;
		logic [IDX_W-1:0]      raddr;
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [COEFF_BITS-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic           start;
		logic [Q_W-1:0] a;
		logic [Q_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] res;
	} mm_rsp_t;

endpackage

// File: src/ntt_ram.sv
module ntt_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/ntt_mulmod.sv
// Bit-serial (a * b) mod q, one bit of a per cycle, MSB first. Needs b < q.
module ntt_mulmod import ntt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  mm_req_t        req,
	input  logic [Q_W-1:0] q,
	output mm_rsp_t        rsp
);

	logic [Q_W-1:0]    r_q, a_q, b_q;
	logic [MCNT_W-1:0] cnt_q;
	logic              run_q, done_q;
	logic [Q_W:0]      r2, r2m, t, tm, qx;

	always_comb begin
		qx  = {1'b0, q};
		r2  = {r_q, 1'b0};
		r2m = (r2 >= qx) ? r2 - qx : r2;
		t   = r2m + (a_q[Q_W-1] ? {1'b0, b_q} : '0);
		tm  = (t >= qx) ? t - qx : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			cnt_q <= MCNT_W'(Q_W - 1);
		end else if (run_q) begin
			r_q   <= tm[Q_W-1:0];
			a_q   <= {a_q[Q_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = r_q;

endmodule

// File: src/ntt_ctrl.sv
// Run sequencer: stage twiddles, butterflies over the store, final scaling (inverse mode only).
module ntt_ctrl import ntt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cfg_t                  cfg,
	input  logic                  fin_ok,
	input  logic [COEFF_BITS-1:0] rdata,
	input  mm_rsp_t               mm_rsp,
	output mm_req_t               mm_req,
	output ram_req_t              ram_req,
	output logic                  busy,
	output logic                  fin
);

	ctrl_state_t state_q, state_d;
	logic        started_q;

	logic [STG_W-1:0] stage_q, exp_q, exp_init;
	logic [IDX_W-1:0] half_q, lo_q, j_q, cnt_q, hi_idx;
	logic [Q_W-1:0]   w_q, step_q, ilfr_q, u_q, v_q, ur_q, vr_q, hv_q;
	logic [Q_W-1:0]   one, root, sum_mod, diff_mod;
	logic [Q_W:0]     sum_x, diff_x;
	logic             is_mul, mm_done, grp_end, stage_end, last_stage;

	always_comb begin
		one        = (cfg.q > Q_W'(1)) ? Q_W'(1) : '0;
		root       = cfg.inv_mode ? cfg.bwd_root : cfg.fwd_root;
		hi_idx     = lo_q + half_q;
		grp_end    = (j_q == half_q - 1'b1);
		stage_end  = (cnt_q == IDX_W'(LENGTH / 2 - 1));
		last_stage = (stage_q == STG_W'(LOG2N - 1));
		exp_init   = cfg.inv_mode ? STG_W'(LOG2N - 1) - stage_q : stage_q;
		sum_x      = {1'b0, ur_q} + {1'b0, vr_q};
		sum_mod    = (sum_x >= {1'b0, cfg.q}) ? Q_W'(sum_x - {1'b0, cfg.q}) : sum_x[Q_W-1:0];
		diff_x     = (ur_q >= vr_q) ? {1'b0, ur_q} - {1'b0, vr_q}
		                            : {1'b0, ur_q} + {1'b0, cfg.q} - {1'b0, vr_q};
		diff_mod   = diff_x[Q_W-1:0];
	end

	// multiplier operands per state
	always_comb begin
		is_mul   = 1'b1;
		mm_req.a = '0;
		mm_req.b = one;
		case (state_q)
			ST_ILF:    mm_req.a = cfg.ilf;
			ST_STG:    mm_req.a = root;
			ST_SQR: begin
				mm_req.a = step_q;
				mm_req.b = step_q;
			end
			ST_MUL_U:  mm_req.a = u_q;
			ST_MUL_V: begin
				mm_req.a = v_q;
				mm_req.b = cfg.inv_mode ? w_q : one;
			end
			ST_MUL_D: begin
				mm_req.a = diff_mod;
				mm_req.b = w_q;
			end
			ST_MUL_W: begin
				mm_req.a = w_q;
				mm_req.b = step_q;
			end
			ST_SC_MUL: begin
				mm_req.a = u_q;
				mm_req.b = ilfr_q;
			end
			default:   is_mul = 1'b0;
		endcase
		mm_req.start = is_mul && !started_q;
		mm_done      = mm_rsp.done && started_q;
	end

	always_comb begin
		state_d = state_q;
		ram_req = '0;
		fin     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (cfg.q == '0) ? ST_FIN : ST_ILF;
				end
			end
			ST_ILF: begin
				if (mm_done) state_d = ST_STG;
			end
			ST_STG: begin
				if (mm_done) state_d = (exp_init == '0) ? ST_RD_LO : ST_SQR;
			end
			ST_SQR: begin
				if (mm_done && exp_q == STG_W'(1)) state_d = ST_RD_LO;
			end
			ST_RD_LO: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = lo_q;
				state_d       = ST_RD_HI;
			end
			ST_RD_HI: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = hi_idx;
				state_d       = ST_CAP_V;
			end
			ST_CAP_V:  state_d = ST_MUL_U;
			ST_MUL_U: begin
				if (mm_done) state_d = ST_MUL_V;
			end
			ST_MUL_V: begin
				if (mm_done) state_d = cfg.inv_mode ? ST_WR_LO : ST_MUL_D;
			end
			ST_MUL_D: begin
				if (mm_done) state_d = ST_WR_LO;
			end
			ST_WR_LO: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = lo_q;
				ram_req.wdata = sum_mod[COEFF_BITS-1:0];
				state_d       = ST_WR_HI;
			end
			ST_WR_HI: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = hi_idx;
				ram_req.wdata = cfg.inv_mode ? diff_mod[COEFF_BITS-1:0] : hv_q[COEFF_BITS-1:0];
				if (stage_end) begin
					if (last_stage) state_d = cfg.inv_mode ? ST_SC_RD : ST_FIN;
					else            state_d = ST_STG;
				end else if (grp_end) begin
					state_d = ST_RD_LO;
				end else begin
					state_d = ST_MUL_W;
				end
			end
			ST_MUL_W: begin
				if (mm_done) state_d = ST_RD_LO;
			end
			ST_SC_RD: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = lo_q;
				state_d       = ST_SC_WAIT;
			end
			ST_SC_WAIT: state_d = ST_SC_MUL;
			ST_SC_MUL: begin
				if (mm_done) state_d = ST_SC_WR;
			end
			ST_SC_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = lo_q;
				ram_req.wdata = hv_q[COEFF_BITS-1:0];
				state_d       = (lo_q == IDX_W'(LENGTH - 1)) ? ST_FIN : ST_SC_RD;
			end
			ST_FIN: begin
				if (fin_ok) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mm_req.start)  started_q <= 1'b1;
			else if (mm_done)  started_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:    stage_q <= '0;
			ST_ILF: begin
				if (mm_done) ilfr_q <= mm_rsp.res;
			end
			ST_STG: begin
				if (mm_done) begin
					step_q <= mm_rsp.res;
					exp_q  <= exp_init;
					half_q <= cfg.inv_mode ? IDX_W'(1) << stage_q
					                       : IDX_W'(LENGTH >> (32'(stage_q) + 1));
					lo_q   <= '0;
					j_q    <= '0;
					cnt_q  <= '0;
					w_q    <= one;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					step_q <= mm_rsp.res;
					exp_q  <= exp_q - 1'b1;
				end
			end
			ST_RD_HI:   u_q <= Q_W'(rdata);
			ST_CAP_V:   v_q <= Q_W'(rdata);
			ST_MUL_U: begin
				if (mm_done) ur_q <= mm_rsp.res;
			end
			ST_MUL_V: begin
				if (mm_done) vr_q <= mm_rsp.res;
			end
			ST_MUL_D: begin
				if (mm_done) hv_q <= mm_rsp.res;
			end
			ST_WR_HI: begin
				cnt_q <= cnt_q + 1'b1;
				if (stage_end) begin
					stage_q <= stage_q + 1'b1;
					lo_q    <= '0;
				end else if (grp_end) begin
					lo_q <= hi_idx + 1'b1;
					j_q  <= '0;
					w_q  <= one;
				end else begin
					lo_q <= lo_q + 1'b1;
					j_q  <= j_q + 1'b1;
				end
			end
			ST_MUL_W: begin
				if (mm_done) w_q <= mm_rsp.res;
			end
			ST_SC_WAIT: u_q <= Q_W'(rdata);
			ST_SC_MUL: begin
				if (mm_done) hv_q <= mm_rsp.res;
			end
			ST_SC_WR:   lo_q <= lo_q + 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: src/radix2_ntt_forward_inverse_core.sv
// Write request: one per cycle while in_ready is high. Read request: result queued at the edge
// after accept, offered from the next cycle on; one per cycle while in_ready is high.
// Run request: butterflies over every stage, with twiddle set-up per stage, and in inverse mode a
// final scaling pass; run time is set by the bit-serial modular multiplier that forms each product.
// No request is taken during a run; a zero modulus skips the transform. Reset (arst_n low,
// async) clears control, output queue and registers to defaults; the store is not cleared.
`include "assert_macros.svh"

module radix2_ntt_forward_inverse_core import ntt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [9:0]  index,
	input  logic [30:0] value,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [30:0] coefficient,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [Q_W-1:0] modulus_q, fwd_root_q, bwd_root_q, ilf_q;
	logic           inv_mode_q;
	logic           cfg_wr;
	cfg_t           cfg;

	// request side
	logic     acc, ctrl_busy, fin, fin_ok, rd_s1;
	ram_req_t ctrl_ram, ram_req;
	logic [COEFF_BITS-1:0] rdata;
	mm_req_t  mm_req;
	mm_rsp_t  mm_rsp;

	// two-entry result queue; head is entry 0
	logic                  oq_kind_q [2];
	logic [COEFF_BITS-1:0] oq_coef_q [2];
	logic [1:0]            oq_cnt_q;
	logic                  push, pop, push_kind, push_pos;
	logic [COEFF_BITS-1:0] push_coef;
	logic [2:0]            room_used;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= Q_W'(12289);
			fwd_root_q <= Q_W'(1);
			bwd_root_q <= Q_W'(1);
			ilf_q      <= Q_W'(1);
			inv_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MODULUS:  modulus_q  <= pwdata[Q_W-1:0];
				REG_FWD_ROOT: fwd_root_q <= pwdata[Q_W-1:0];
				REG_INV_ROOT: bwd_root_q <= pwdata[Q_W-1:0];
				REG_INV_LEN:  ilf_q      <= pwdata[Q_W-1:0];
				REG_INV_MODE: inv_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MODULUS:  prdata = 32'(modulus_q);
			REG_FWD_ROOT: prdata = 32'(fwd_root_q);
			REG_INV_ROOT: prdata = 32'(bwd_root_q);
			REG_INV_LEN:  prdata = 32'(ilf_q);
			REG_INV_MODE: prdata = 32'(inv_mode_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.q        = modulus_q;
	assign cfg.fwd_root = fwd_root_q;
	assign cfg.bwd_root = bwd_root_q;
	assign cfg.ilf      = ilf_q;
	assign cfg.inv_mode = inv_mode_q;

	// Take a request only when the queue can absorb every result already in
	// flight plus this one.
	assign pop       = out_valid && out_ready;
	assign room_used = 3'(oq_cnt_q) + 3'(rd_s1) - 3'(pop);
	assign in_ready  = !ctrl_busy && (room_used <= 3'd1);
	assign acc       = in_valid && in_ready;

	// Store port: sequencer owns it during a run, else requests stream in.
	always_comb begin
		if (ctrl_busy) begin
			ram_req = ctrl_ram;
		end else begin
			ram_req.we    = acc && (cmd == CMD_WRITE);
			ram_req.waddr = index[IDX_W-1:0];
			ram_req.wdata = value[COEFF_BITS-1:0];
			ram_req.re    = acc && (cmd == CMD_READ);
			ram_req.raddr = index[IDX_W-1:0];
		end
	end

	ntt_ram #(
		.WIDTH(COEFF_BITS),
		.DEPTH(LENGTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(rdata)
	);

	ntt_mulmod u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mm_req),
		.q     (modulus_q),
		.rsp   (mm_rsp)
	);

	// finish result needs a free queue slot
	assign fin_ok = (oq_cnt_q != 2'd2);

	ntt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc && (cmd == CMD_RUN)),
		.cfg    (cfg),
		.fin_ok (fin_ok),
		.rdata  (rdata),
		.mm_rsp (mm_rsp),
		.mm_req (mm_req),
		.ram_req(ctrl_ram),
		.busy   (ctrl_busy),
		.fin    (fin)
	);

	// read data lands in the cycle after the read request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_s1 <= 1'b0;
		else         rd_s1 <= acc && (cmd == CMD_READ);
	end

	assign push      = rd_s1 || fin;
	assign push_kind = fin ? KIND_FIN : KIND_READ;
	assign push_coef = fin ? '0 : rdata;
	// slot after the pop: entry 1 only if something stays at the head
	assign push_pos  = oq_cnt_q[1] | (oq_cnt_q[0] & ~pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) oq_cnt_q <= '0;
		else         oq_cnt_q <= oq_cnt_q + 2'(push) - 2'(pop);
	end

	always_ff @(posedge clk) begin
		if (push && !push_pos) begin
			oq_kind_q[0] <= push_kind;
			oq_coef_q[0] <= push_coef;
		end else if (pop) begin
			oq_kind_q[0] <= oq_kind_q[1];
			oq_coef_q[0] <= oq_coef_q[1];
		end
		if (push && push_pos) begin
			oq_kind_q[1] <= push_kind;
			oq_coef_q[1] <= push_coef;
		end
	end

	assign out_valid   = (oq_cnt_q != 2'd0);
	assign kind        = oq_kind_q[0];
	assign coefficient = 31'(oq_coef_q[0]);

	// no request slips in while a run owns the store
	`ASSERT_IMPL(a_no_acc_busy, clk, arst_n, acc, !ctrl_busy)
	// a run request hands the store to the sequencer
	`ASSERT_NEXT(a_run_starts, clk, arst_n, acc && cmd == CMD_RUN, ctrl_busy)
	// read in flight always has a queue slot waiting
	`ASSERT_IMPL(a_rd_room, clk, arst_n, rd_s1, oq_cnt_q != 2'd2 || pop)
	// finish never collides with a read push
	`ASSERT_IMPL(a_fin_alone, clk, arst_n, fin, !rd_s1 && oq_cnt_q != 2'd2)

endmodule

// File: sim/ntt_result_checker.sv
`timescale 1ns / 1ps

module ntt_result_checker import ntt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [9:0]  index,
	input  logic [30:0] value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [30:0] coefficient,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          results_owed
);

	typedef struct {
		logic        kind;
		logic [30:0] coeff;
	} ntt_result_t;

	ntt_result_t owed_q[$];
	logic [30:0] store_m [LENGTH];
	logic [30:0] q_m, fwd_m, inv_m, ilf_m;
	logic        mode_m;

	assign results_owed = owed_q.size();

	function automatic logic [30:0] mul_mod(longint unsigned a, longint unsigned b,
			longint unsigned m);
		return (a * b) % m;
	endfunction

	function automatic logic [30:0] pow_mod(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned r;
		r = 1 % m;
		b = b % m;
		while (e > 0) begin
			if (e[0]) r = mul_mod(r, b, m);
			b = mul_mod(b, b, m);
			e = e >> 1;
		end
		return r;
	endfunction

	// in-place transform of the model store, as the block should do it
	function automatic void transform_store();
		longint unsigned q, u, v, d, w, stp;
		int len, half, lo, hi;
		q = q_m;
		if (q == 0) return;
		if (!mode_m) begin
			for (len = LENGTH; len >= 2; len = len / 2) begin
				half = len / 2;
				stp = pow_mod(fwd_m, LENGTH / len, q);
				for (int i = 0; i < LENGTH; i += len) begin
					w = 1 % q;
					for (int j = 0; j < half; j++) begin
						lo = i + j;
						hi = lo + half;
						if (hi < LENGTH) begin
							u = store_m[lo];
							v = store_m[hi];
							d = (u + q - (v % q)) % q;
							store_m[lo] = (u + v) % q;
							store_m[hi] = mul_mod(d, w, q);
						end
						w = mul_mod(w, stp, q);
					end
				end
			end
		end else begin
			for (len = 2; len <= LENGTH; len = len * 2) begin
				half = len / 2;
				stp = pow_mod(inv_m, LENGTH / len, q);
				for (int i = 0; i < LENGTH; i += len) begin
					w = 1 % q;
					for (int j = 0; j < half; j++) begin
						lo = i + j;
						hi = lo + half;
						if (hi < LENGTH) begin
							u = store_m[lo];
							v = mul_mod(store_m[hi], w, q);
							store_m[lo] = (u + v) % q;
							store_m[hi] = (u + q - v) % q;
						end
						w = mul_mod(w, stp, q);
					end
				end
			end
			for (int i = 0; i < LENGTH; i++)
				store_m[i] = mul_mod(store_m[i], ilf_m, q);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ntt_result_t exp_r;
		if (!arst_n) begin
			q_m    <= 31'd12289;
			fwd_m  <= 31'd1;
			inv_m  <= 31'd1;
			ilf_m  <= 31'd1;
			mode_m <= 1'b0;
			owed_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MODULUS:  q_m    <= pwdata[30:0];
					REG_FWD_ROOT: fwd_m  <= pwdata[30:0];
					REG_INV_ROOT: inv_m  <= pwdata[30:0];
					REG_INV_LEN:  ilf_m  <= pwdata[30:0];
					REG_INV_MODE: mode_m <= pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (cmd)
					CMD_WRITE: store_m[index % LENGTH] = value;
					CMD_RUN: begin
						transform_store();
						owed_q.push_back('{KIND_FIN, 31'd0});
					end
					CMD_READ: owed_q.push_back('{KIND_READ, store_m[index % LENGTH]});
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$error("unexpected result: kind %0d coefficient %0d", kind, coefficient);
					fail_count++;
				end else begin
					exp_r = owed_q.pop_front();
					if (kind !== exp_r.kind) begin
						$error("kind: expected %0d, got %0d", exp_r.kind, kind);
						fail_count++;
					end
					if (coefficient !== exp_r.coeff) begin
						$error("coefficient: expected %0d, got %0d", exp_r.coeff, coefficient);
						fail_count++;
					end
				end
			end
		end
	end

	initial fail_count = 0;

endmodule

// File: sim/tb_radix2_ntt_forward_inverse_core.sv
`timescale 1ns / 1ps

module tb_radix2_ntt_forward_inverse_core;
	import ntt_pkg::*;

	// two full transforms, one forward and one inverse, dominate the run time
	localparam longint CYCLE_LIMIT = 64'd5_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_WRITE;
	logic [9:0]  index = '0;
	logic [30:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [30:0] coefficient;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          results_owed;
	longint      cycles = 0;
	bit          no_gaps = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	radix2_ntt_forward_inverse_core dut (.*);

	ntt_result_checker chk (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly short gaps, the odd long one, none at all during bursts
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		int stall;
		if (stall > 0) begin
			stall--;
			out_ready <= 1'b0;
		end else begin
			stall = pick_gap();
			out_ready <= (stall == 0);
		end
	end

	// one request; valid is only dropped when a gap is actually inserted
	task automatic send_request(logic [1:0] c, logic [9:0] idx, logic [30:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		index    <= idx;
		value    <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// setup then access cycle; psel drops for a cycle before the next write
	task automatic reg_write(logic [2:0] reg_idx, logic [30:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= {1'b0, data};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and let every owed result drain before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic [30:0] q, logic [30:0] fr, logic [30:0] ir,
			logic [30:0] ilf, logic mode);
		reg_write(REG_MODULUS, q);
		reg_write(REG_FWD_ROOT, fr);
		reg_write(REG_INV_ROOT, ir);
		reg_write(REG_INV_LEN, ilf);
		reg_write(REG_INV_MODE, 31'(mode));
	endtask

	initial begin
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-size modulus, forward transform
		set_config(31'h7FFF_FFFF, 31'd1_234_567, 31'h7FFF_FFFE, 31'd1, 1'b0);

		// directed: field extremes, unused command, overwrite
		send_request(CMD_WRITE, 10'd0, 31'd0);
		send_request(CMD_WRITE, 10'd1023, 31'h7FFF_FFFF);
		send_request(CMD_READ, 10'd1023, 31'd0);
		send_request(CMD_READ, 10'd0, 31'h7FFF_FFFF);
		send_request(2'd3, 10'h3FF, 31'h7FFF_FFFF);
		send_request(2'd3, 10'd0, 31'd0);
		send_request(CMD_WRITE, 10'd5, 31'h2AAA_AAAA);
		send_request(CMD_READ, 10'd5, 31'd0);
		send_request(CMD_WRITE, 10'd5, 31'h5555_5555);
		send_request(CMD_READ, 10'd5, 31'd0);
		send_request(CMD_WRITE, 10'h2AA, 31'h7FFF_FFFE);
		send_request(CMD_READ, 10'h2AA, 31'd0);

		// fill the whole store so a transform never touches an unwritten entry
		no_gaps = 1'b1;
		for (int i = 0; i < LENGTH; i++)
			send_request(CMD_WRITE, 10'(i), (i % 97 == 0) ? 31'h7FFF_FFFF : 31'($urandom));
		no_gaps = 1'b0;
		send_request(CMD_RUN, 10'($urandom), 31'($urandom));
		for (int i = 0; i < 12; i++)
			send_request(CMD_READ, 10'($urandom), 31'd0);
		drain();

		// small modulus, inverse transform with scaling
		set_config(31'd3, 31'd2, 31'd2, 31'd2, 1'b1);
		send_request(CMD_RUN, 10'd0, 31'd0);
		for (int i = 0; i < 12; i++)
			send_request(CMD_READ, 10'($urandom), 31'd0);
		drain();

		// random phases; zero modulus keeps runs short and the store untouched by them
		for (int ph = 0; ph < 4; ph++) begin
			set_config(31'd0, (ph == 0) ? 31'd1 : 31'($urandom),
				(ph == 1) ? 31'h7FFF_FFFE : 31'($urandom),
				(ph == 2) ? 31'h7FFF_FFFE : 31'($urandom), ph[0]);
			no_gaps = (ph == 3);
			for (int n = 0; n < 190; n++) begin
				r = $urandom_range(0, 99);
				if (r < 42)
					send_request(CMD_WRITE, 10'($urandom), 31'($urandom));
				else if (r < 84)
					send_request(CMD_READ, 10'($urandom), 31'($urandom));
				else if (r < 94)
					send_request(CMD_RUN, 10'($urandom), 31'($urandom));
				else
					send_request(2'd3, 10'($urandom), 31'($urandom));
			end
			no_gaps = 1'b0;
			drain();
		end

		in_valid <= 1'b0;
		while (results_owed != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/ntt_pkg.sv
src/ntt_ram.sv
src/ntt_mulmod.sv
src/ntt_ctrl.sv
src/radix2_ntt_forward_inverse_core.sv
sim/ntt_result_checker.sv
sim/tb_radix2_ntt_forward_inverse_core.sv
